[rtl/dtfd_pkg.sv]
// ----------------------------------------------------------------------------
// dtfd_pkg
// Shared constants and types for the double to fixed decimal digit converter.
// ----------------------------------------------------------------------------
package dtfd_pkg;

  localparam int SIG_W      = 52;   // stored significand bits
  localparam int INT_W      = 72;   // integer part bits (values below 2^72)
  localparam int FRAC_W     = 128;  // fraction part bits
  localparam int WIDE_W     = INT_W + FRAC_W;
  localparam int INT_DIGITS = 22;   // decimal digits of 2^72 - 1
  localparam int SHIFT_W    = 8;

  localparam logic [10:0] BEXP_MAX = 11'd1094;  // above: out of range
  localparam logic [10:0] BEXP_MIN = 11'd947;   // below: exponent under -128

  typedef struct packed {
    logic load;
    logic step;
  } frac_ctl_t;

endpackage

[rtl/dtfd_frac_unit.sv]
// ----------------------------------------------------------------------------
// dtfd_frac_unit
// Binary fraction register; each step multiplies by ten and yields one digit.
// ----------------------------------------------------------------------------
module dtfd_frac_unit (
  input  logic                      clk,
  input  dtfd_pkg::frac_ctl_t       ctl,
  input  logic [dtfd_pkg::FRAC_W-1:0] load_val,
  output logic [3:0]                digit,
  output logic                      is_zero,
  output logic                      round_bit
);
  import dtfd_pkg::*;

  logic [FRAC_W-1:0] frac_r;
  logic [FRAC_W-1:0] frac_nxt;
  logic [FRAC_W+3:0] prod;

  // x*10 = x*8 + x*2
  assign prod      = {1'b0, frac_r, 3'b000} + {3'b000, frac_r, 1'b0};
  assign digit     = prod[FRAC_W+3:FRAC_W];
  assign is_zero   = (frac_r == '0);
  assign round_bit = frac_r[FRAC_W-1];

  always_comb begin
    frac_nxt = frac_r;
    if (ctl.load) begin
      frac_nxt = load_val;
    end else if (ctl.step) begin
      frac_nxt = prod[FRAC_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    frac_r <= frac_nxt;
  end

endmodule

[rtl/double_to_fixed_decimal_digits_top.sv]
// ----------------------------------------------------------------------------
// double_to_fixed_decimal_digits_top
// Converts a double bit pattern to its fixed-point decimal digits.
// ----------------------------------------------------------------------------
// One value is converted at a time. After a beat is taken the block aligns
// the value, converts the integer part by shift-and-add-3 at one bit per
// cycle, produces one fraction digit per cycle (up to frac_digits, or fewer
// once the fraction is zero), runs the rounding carry through the digit
// register one digit per cycle, then skips leading zeros one digit per cycle
// before sending one beat per significant digit, each beat held by output
// stalls. Leading zeros skipped plus digits sent never exceed 22 + MAX_FRAC
// (42 by default). An out-of-range value skips the conversion and sends one
// out-of-range beat. A new value is taken once the last beat of the previous
// one sits in the output register.
module double_to_fixed_decimal_digits_top #(
  parameter int MAX_FRAC = 20
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [71:0] in_tdata,   // [63:0] value_bits, [68:64] frac_digits
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [3:0] digit, [9:4] point
  output logic [1:0]  out_tuser,  // [0] has_digit, [1] out_of_range
  output logic        out_tlast
);
  import dtfd_pkg::*;

  localparam int NDIG  = INT_DIGITS + MAX_FRAC;
  localparam int DIG_W = NDIG * 4;
  localparam int S_W   = $clog2(NDIG + 1);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_LOAD  = 3'd1;
  localparam logic [2:0] ST_DAB   = 3'd2;
  localparam logic [2:0] ST_FRAC  = 3'd3;
  localparam logic [2:0] ST_ROUND = 3'd4;
  localparam logic [2:0] ST_NORM  = 3'd5;
  localparam logic [2:0] ST_EMIT  = 3'd6;

  logic [2:0]       state_r, state_nxt;
  logic [10:0]      bexp_r, bexp_nxt;
  logic [SIG_W-1:0] sig_r, sig_nxt;
  logic [4:0]       frac_r, frac_nxt;
  logic [INT_W-1:0] ibits_r, ibits_nxt;
  logic [DIG_W-1:0] dig_r, dig_nxt;
  logic [6:0]       cnt_r, cnt_nxt;
  logic [4:0]       fcnt_r, fcnt_nxt;
  logic [S_W-1:0]   s_r, s_nxt;
  logic             carry_r, carry_nxt;
  logic             oor_r, oor_nxt;
  logic             empty_r, empty_nxt;

  logic             out_valid_r, out_valid_nxt;
  logic [3:0]       out_digit_r, out_digit_nxt;
  logic [5:0]       out_point_r, out_point_nxt;
  logic             out_has_r, out_has_nxt;
  logic             out_oor_r, out_oor_nxt;
  logic             out_last_r, out_last_nxt;

  frac_ctl_t         fctl;
  logic [3:0]        f_digit;
  logic              f_zero;
  logic              f_round;
  logic [WIDE_W-1:0] wide_val;
  logic [SHIFT_W-1:0] shamt;
  logic [DIG_W-1:0]  dab;
  logic [4:0]        rsum;
  logic [3:0]        rdig;
  logic [6:0]        point_w;
  logic [4:0]        frac_in;

  dtfd_frac_unit u_frac (
    .clk       (clk),
    .ctl       (fctl),
    .load_val  (wide_val[FRAC_W-1:0]),
    .digit     (f_digit),
    .is_zero   (f_zero),
    .round_bit (f_round)
  );

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'b0, out_point_r, out_digit_r};
  assign out_tuser  = {out_oor_r, out_has_r};
  assign out_tlast  = out_last_r;

  assign frac_in = (in_tdata[68:64] > 5'(MAX_FRAC)) ? 5'(MAX_FRAC) : in_tdata[68:64];
  assign shamt   = SHIFT_W'(bexp_r - BEXP_MIN);
  assign point_w = 7'(NDIG) - 7'(fcnt_r) - 7'(s_r);

  always_comb begin
    if (bexp_r < BEXP_MIN) begin
      wide_val = '0;
    end else begin
      wide_val = WIDE_W'({1'b1, sig_r}) << shamt;
    end
  end

  always_comb begin
    for (int i = 0; i < NDIG; i++) begin
      dab[i*4 +: 4] = (dig_r[i*4 +: 4] >= 4'd5) ? dig_r[i*4 +: 4] + 4'd3 : dig_r[i*4 +: 4];
    end
  end

  assign rsum = 5'(dig_r[3:0]) + 5'(carry_r);
  assign rdig = (rsum == 5'd10) ? 4'd0 : rsum[3:0];

  always_comb begin
    state_nxt     = state_r;
    bexp_nxt      = bexp_r;
    sig_nxt       = sig_r;
    frac_nxt      = frac_r;
    ibits_nxt     = ibits_r;
    dig_nxt       = dig_r;
    cnt_nxt       = cnt_r;
    fcnt_nxt      = fcnt_r;
    s_nxt         = s_r;
    carry_nxt     = carry_r;
    oor_nxt       = oor_r;
    empty_nxt     = empty_r;
    fctl          = '0;
    out_valid_nxt = out_valid_r & ~out_tready;
    out_digit_nxt = out_digit_r;
    out_point_nxt = out_point_r;
    out_has_nxt   = out_has_r;
    out_oor_nxt   = out_oor_r;
    out_last_nxt  = out_last_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          sig_nxt   = in_tdata[SIG_W-1:0];
          bexp_nxt  = in_tdata[62:52];
          frac_nxt  = frac_in;
          state_nxt = ST_LOAD;
        end
      end
      ST_LOAD: begin
        oor_nxt   = (bexp_r > BEXP_MAX);
        empty_nxt = 1'b0;
        ibits_nxt = wide_val[WIDE_W-1:FRAC_W];
        dig_nxt   = '0;
        cnt_nxt   = '0;
        fcnt_nxt  = '0;
        s_nxt     = '0;
        fctl.load = 1'b1;
        state_nxt = (bexp_r > BEXP_MAX) ? ST_EMIT : ST_DAB;
      end
      ST_DAB: begin
        dig_nxt   = {dab[DIG_W-2:0], ibits_r[INT_W-1]};
        ibits_nxt = {ibits_r[INT_W-2:0], 1'b0};
        cnt_nxt   = cnt_r + 7'd1;
        if (cnt_r == 7'(INT_W - 1)) begin
          state_nxt = ST_FRAC;
        end
      end
      ST_FRAC: begin
        if (fcnt_r == frac_r || f_zero) begin
          carry_nxt = f_round;
          cnt_nxt   = '0;
          state_nxt = ST_ROUND;
        end else begin
          fctl.step = 1'b1;
          dig_nxt   = {dig_r[DIG_W-5:0], f_digit};
          fcnt_nxt  = fcnt_r + 5'd1;
        end
      end
      ST_ROUND: begin
        dig_nxt   = {rdig, dig_r[DIG_W-1:4]};
        carry_nxt = (rsum == 5'd10);
        cnt_nxt   = cnt_r + 7'd1;
        if (cnt_r == 7'(NDIG - 1)) begin
          state_nxt = ST_NORM;
        end
      end
      ST_NORM: begin
        if (dig_r == '0) begin
          empty_nxt = 1'b1;
          state_nxt = ST_EMIT;
        end else if (dig_r[DIG_W-1:DIG_W-4] != 4'd0) begin
          state_nxt = ST_EMIT;
        end else begin
          dig_nxt = {dig_r[DIG_W-5:0], 4'd0};
          s_nxt   = s_r + S_W'(1);
        end
      end
      ST_EMIT: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          if (oor_r) begin
            out_digit_nxt = 4'd0;
            out_has_nxt   = 1'b0;
            out_point_nxt = 6'd0;
            out_oor_nxt   = 1'b1;
            out_last_nxt  = 1'b1;
            state_nxt     = ST_IDLE;
          end else if (empty_r) begin
            out_digit_nxt = 4'd0;
            out_has_nxt   = 1'b0;
            out_point_nxt = 6'd0 - 6'(frac_r);
            out_oor_nxt   = 1'b0;
            out_last_nxt  = 1'b1;
            state_nxt     = ST_IDLE;
          end else begin
            out_digit_nxt = dig_r[DIG_W-1:DIG_W-4];
            out_has_nxt   = 1'b1;
            out_point_nxt = point_w[5:0];
            out_oor_nxt   = 1'b0;
            out_last_nxt  = (dig_r[DIG_W-5:0] == '0);
            dig_nxt       = {dig_r[DIG_W-5:0], 4'd0};
            if (dig_r[DIG_W-5:0] == '0) begin
              state_nxt = ST_IDLE;
            end
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    bexp_r      <= bexp_nxt;
    sig_r       <= sig_nxt;
    frac_r      <= frac_nxt;
    ibits_r     <= ibits_nxt;
    dig_r       <= dig_nxt;
    cnt_r       <= cnt_nxt;
    fcnt_r      <= fcnt_nxt;
    s_r         <= s_nxt;
    carry_r     <= carry_nxt;
    oor_r       <= oor_nxt;
    empty_r     <= empty_nxt;
    out_digit_r <= out_digit_nxt;
    out_point_r <= out_point_nxt;
    out_has_r   <= out_has_nxt;
    out_oor_r   <= out_oor_nxt;
    out_last_r  <= out_last_nxt;
  end

endmodule

[dv/double_to_fixed_decimal_digits_top_tb.sv]
// ----------------------------------------------------------------------------
// double_to_fixed_decimal_digits_top_tb
// Drives double bit patterns and fraction digit counts into the converter,
// predicts the digit beats of each value and checks every output beat.
// ----------------------------------------------------------------------------
module double_to_fixed_decimal_digits_top_tb;

  localparam int MAX_FRAC   = 20;
  localparam int N_RANDOM   = 80;
  localparam int WDOG_LIMIT = 4000;
  localparam int DRAIN      = 300;

  typedef struct packed {
    logic [3:0] digit;
    logic       has_digit;
    logic [5:0] point;
    logic       oor;
    logic       last;
  } digit_beat_t;

  typedef struct {
    logic [63:0] bits;
    logic [4:0]  frac;
    logic        typed;
    digit_beat_t first;
  } stim_row_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [71:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [15:0] out_tdata;
  logic [1:0]  out_tuser;
  logic        out_tlast;

  digit_beat_t expected_beats[$];
  digit_beat_t first_pred;
  int          n_errors;
  int          n_values;
  int          n_beats;
  int          idle_cycles;
  bit          rx_stall_on;
  bit          no_gaps;
  bit          stim_done;

  double_to_fixed_decimal_digits_top #(.MAX_FRAC(MAX_FRAC)) DUT (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .out_tlast(out_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  task automatic report_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] want);
    $display("mismatch at beat %0d: %s got %0d want %0d", n_beats, what, got, want);
    n_errors++;
  endtask

  function automatic digit_beat_t mk_beat(logic [3:0] d, logic h, logic [5:0] p,
                                          logic o, logic l);
    digit_beat_t b;
    b.digit = d; b.has_digit = h; b.point = p; b.oor = o; b.last = l;
    return b;
  endfunction

  // Exact digits of the value, fraction digits by 5x steps, half-up rounding.
  task automatic predict_digits(input logic [63:0] bits, input logic [4:0] frac_in);
    logic [10:0]  bexp;
    logic [52:0]  sig;
    int           e, n, len, pnt, lead, fr, k;
    logic [127:0] ipart, fpart, five;
    logic [3:0]   dig[42];
    logic [3:0]   tmp[24];
    int           cnt;
    fr = (frac_in > MAX_FRAC) ? MAX_FRAC : frac_in;
    bexp = bits[62:52];
    len = 0; pnt = 0;
    if (bexp > 11'd1094) begin
      expected_beats.push_back(mk_beat(4'd0, 1'b0, 6'd0, 1'b1, 1'b1));
      return;
    end
    sig = {1'b0, bits[51:0]};
    if (bexp == 0) e = -1074;
    else begin
      sig[52] = 1'b1;
      e = int'(bexp) - 1075;
    end
    if (e >= -128) begin
      n = 0;
      fpart = '0;
      if (e >= 0) ipart = 128'(sig) << e;
      else begin
        n = -e;
        ipart = 128'(sig) >> n;
        fpart = (n >= 64) ? 128'(sig) : 128'(sig) & ((128'd1 << n) - 1);
      end
      cnt = 0;
      while (ipart != 0 && cnt < 24) begin
        tmp[cnt] = 4'(ipart % 10);
        ipart = ipart / 10;
        cnt++;
      end
      for (k = 0; k < cnt; k++) dig[len++] = tmp[cnt - 1 - k];
      pnt = len;
      if (e < 0) begin
        for (k = 0; k < fr && fpart != 0 && n > 0; k++) begin
          five = (fpart << 2) + fpart;
          n--;
          dig[len++] = 4'(five >> n);
          fpart = (n >= 128) ? five : five & ((128'd1 << n) - 1);
        end
        if (n > 0 && fpart[n - 1]) begin
          if (len == 0) begin
            dig[0] = 4'd1; len = 1; pnt = 1;
          end else begin
            dig[len - 1]++;
            for (k = len - 1; k > 0; k--) begin
              if (dig[k] != 4'd10) break;
              dig[k] = 4'd0;
              dig[k - 1]++;
            end
            if (dig[0] == 4'd10) begin
              dig[0] = 4'd1; pnt++;
            end
          end
        end
      end
    end
    while (len > 0 && dig[len - 1] == 0) len--;
    lead = 0;
    while (lead < len && dig[lead] == 0) lead++;
    if (len - lead == 0) begin
      expected_beats.push_back(mk_beat(4'd0, 1'b0, 6'(-fr), 1'b0, 1'b1));
      return;
    end
    for (k = lead; k < len; k++)
      expected_beats.push_back(mk_beat(dig[k], 1'b1, 6'(pnt - lead), 1'b0, k == len - 1));
  endtask

  task automatic send_value(input logic [63:0] bits, input logic [4:0] frac);
    int gap;
    int w;
    if (!no_gaps && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      gap = $urandom_range(1, 19);
      repeat (gap) @(posedge clk);
    end
    w = expected_beats.size();
    predict_digits(bits, frac);
    first_pred = expected_beats[w];
    in_tvalid <= 1'b1;
    in_tdata  <= {3'b000, frac, bits};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    n_values++;
  endtask

  function automatic logic [63:0] mk_double(logic [10:0] bexp, logic [51:0] mant);
    return {1'($urandom_range(0, 1)), bexp, mant};
  endfunction

  // Output sink: random stall bursts, beat check against the queue.
  initial begin
    int stall;
    digit_beat_t want;
    out_tready = 1'b0;
    stall = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready) begin
        n_beats++;
        if (expected_beats.size() == 0) begin
          $display("unexpected beat %0d", n_beats);
          n_errors++;
        end else begin
          want = expected_beats.pop_front();
          if (out_tdata[3:0] != want.digit)
            report_mismatch("digit", 8'(out_tdata[3:0]), 8'(want.digit));
          if (out_tdata[9:4] != want.point)
            report_mismatch("point", 8'(out_tdata[9:4]), 8'(want.point));
          if (out_tdata[15:10] != 0) report_mismatch("pad", 8'(out_tdata[15:10]), 8'd0);
          if (out_tuser[0] != want.has_digit)
            report_mismatch("has_digit", 8'(out_tuser[0]), 8'(want.has_digit));
          if (out_tuser[1] != want.oor)
            report_mismatch("out_of_range", 8'(out_tuser[1]), 8'(want.oor));
          if (out_tlast != want.last)
            report_mismatch("last", 8'(out_tlast), 8'(want.last));
        end
      end
      if (stall > 0) begin
        stall--;
        out_tready <= 1'b0;
      end else if (!no_gaps && $urandom_range(0, 5) == 0) begin
        stall = $urandom_range(1, 19) - 1;
        out_tready <= 1'b0;
      end else out_tready <= 1'b1;
    end
  end

  // Watchdog on cycles without any accepted beat.
  initial begin
    idle_cycles = 0;
    forever begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles = 0;
      else if (rst_n && !(stim_done && expected_beats.size() == 0)) idle_cycles++;
      if (idle_cycles >= WDOG_LIMIT) begin
        $display("watchdog: no beat for %0d cycles", WDOG_LIMIT);
        $display("double_to_fixed_decimal_digits_top test failed");
        $finish;
      end
    end
  end

  initial begin
    stim_row_t rows[$];
    stim_row_t r;
    int k, kind;
    logic [10:0] be;
    n_errors = 0; n_values = 0; n_beats = 0;
    no_gaps = 1'b0; stim_done = 1'b0;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // bits, frac, typed, first beat
    rows = '{
      '{64'h0000_0000_0000_0000, 5'd0,  1'b1, '{4'd0, 1'b0, 6'd0,  1'b0, 1'b1}},
      '{64'h0000_0000_0000_0000, 5'd20, 1'b1, '{4'd0, 1'b0, -6'sd20, 1'b0, 1'b1}},
      '{64'h8000_0000_0000_0000, 5'd31, 1'b1, '{4'd0, 1'b0, -6'sd20, 1'b0, 1'b1}},
      '{64'h0000_0000_0000_0001, 5'd20, 1'b1, '{4'd0, 1'b0, -6'sd20, 1'b0, 1'b1}},
      '{64'h000F_FFFF_FFFF_FFFF, 5'd5,  1'b1, '{4'd0, 1'b0, -6'sd5, 1'b0, 1'b1}},
      '{64'h7FF0_0000_0000_0000, 5'd3,  1'b1, '{4'd0, 1'b0, 6'd0,  1'b1, 1'b1}},
      '{64'hFFF8_0000_0000_0001, 5'd0,  1'b1, '{4'd0, 1'b0, 6'd0,  1'b1, 1'b1}},
      '{64'h4470_0000_0000_0000, 5'd7,  1'b1, '{4'd0, 1'b0, 6'd0,  1'b1, 1'b1}},
      '{64'h446F_FFFF_FFFF_FFFF, 5'd7,  1'b0, '{default: '0}},
      '{64'h3FF0_0000_0000_0000, 5'd0,  1'b1, '{4'd1, 1'b1, 6'd1,  1'b0, 1'b1}},
      '{64'h3FE0_0000_0000_0000, 5'd0,  1'b1, '{4'd1, 1'b1, 6'd1,  1'b0, 1'b1}},
      '{64'h3FD0_0000_0000_0000, 5'd0,  1'b1, '{4'd0, 1'b0, 6'd0,  1'b0, 1'b1}},
      '{64'h3FB9_9999_9999_999A, 5'd20, 1'b0, '{default: '0}},
      '{64'h3FEF_FFFF_FFFF_FFFF, 5'd3,  1'b0, '{default: '0}},
      '{64'h4058_FFFF_FFFF_FFFF, 5'd10, 1'b0, '{default: '0}},
      '{64'h400921FB54442D18, 5'd20,    1'b0, '{default: '0}},
      '{64'h3B00_0000_0000_0000, 5'd20, 1'b0, '{default: '0}},
      '{64'h37F0_0000_0000_0000, 5'd20, 1'b0, '{default: '0}},
      '{64'h37EF_FFFF_FFFF_FFFF, 5'd20, 1'b0, '{default: '0}},
      '{64'h4330_0000_0000_0001, 5'd20, 1'b0, '{default: '0}},
      '{64'h4415_AF1D_78B5_8C40, 5'd2,  1'b0, '{default: '0}},
      '{64'h3F50_624D_D2F1_A9FC, 5'd2,  1'b0, '{default: '0}},
      '{64'h3FF8_0000_0000_0000, 5'd25, 1'b0, '{default: '0}}
    };
    foreach (rows[i]) begin
      r = rows[i];
      send_value(r.bits, r.frac);
      if (r.typed) begin
        if (first_pred != r.first) begin
          $display("directed row %0d: predicted first beat differs from table", i);
          n_errors++;
        end
      end
    end

    for (k = 0; k < N_RANDOM; k++) begin
      if (k > N_RANDOM - 15) no_gaps = 1'b1;
      kind = $urandom_range(0, 9);
      unique case (kind)
        0: be = 11'($urandom_range(0, 2047));
        1: be = 11'($urandom_range(1075, 1094));
        2: be = 11'($urandom_range(1095, 2047));
        3: be = 11'($urandom_range(0, 946));
        default: be = 11'($urandom_range(947, 1074));
      endcase
      send_value(mk_double(be, {20'($urandom), $urandom}),
                 5'($urandom_range(0, 3) == 0 ? $urandom_range(0, 31)
                                               : $urandom_range(0, 6)));
    end
    in_tvalid <= 1'b0;
    stim_done = 1'b1;

    while (expected_beats.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
    $display("converted %0d values into %0d digit beats, including zero, subnormal,",
             n_values, n_beats);
    $display("tiny, rounding-carry and out-of-range inputs under random stalls");
    if (n_errors == 0 && expected_beats.size() == 0) begin
      $display("double_to_fixed_decimal_digits_top test passed");
    end else begin
      $display("double_to_fixed_decimal_digits_top test failed");
    end
    $finish;
  end

endmodule
